// ----- src/bpt_pkg.sv -----
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the beacon period tracker.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int TIME_BITS  = 32;
  localparam int GUARD_BITS = 31;
  localparam int LIMIT_BITS = 16;
  localparam int SHIFT_BITS = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_BITS  = 2;
  localparam int OUT_DATA_W = 3 * TIME_BITS;

  typedef logic [TIME_BITS-1:0] time_t;

  // event kinds carried on in_tuser
  typedef enum logic [MODE_BITS-1:0] {
    MODE_BEACON  = 2'd0,
    MODE_MISS    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_SEED = 2'd0,
    CFG_GUARD_TIME  = 2'd1,
    CFG_WARMUP_LIM  = 2'd2,
    CFG_SMOOTH_SHFT = 2'd3
  } cfg_idx_t;

  // programmed configuration
  typedef struct packed {
    time_t                  period_seed;
    logic [GUARD_BITS-1:0]  guard_time;
    logic [LIMIT_BITS-1:0]  warmup_limit;
    logic [SHIFT_BITS-1:0]  smoothing_shift;
  } cfg_t;

  // tracker state, including values latched on restart
  typedef struct packed {
    time_t                  period_cur;
    time_t                  last_beacon;
    logic                   have_ref;
    logic [LIMIT_BITS-1:0]  warm_cnt;
    logic                   tracking;
    logic [GUARD_BITS-1:0]  lat_guard;
    logic [LIMIT_BITS-1:0]  lat_limit;
    logic [SHIFT_BITS-1:0]  lat_shift;
  } state_t;

endpackage

// ----- src/bpt_cfg.sv -----
// ----------------------------------------------------------------------------
// bpt_cfg
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module bpt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bpt_pkg::cfg_t                 cfg
);
  import bpt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERIOD_SEED: cfg_nxt.period_seed     = cfg_wdata[TIME_BITS-1:0];
        CFG_GUARD_TIME:  cfg_nxt.guard_time      = cfg_wdata[GUARD_BITS-1:0];
        CFG_WARMUP_LIM:  cfg_nxt.warmup_limit    = cfg_wdata[LIMIT_BITS-1:0];
        CFG_SMOOTH_SHFT: cfg_nxt.smoothing_shift = cfg_wdata[SHIFT_BITS-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/bpt_update.sv -----
// ----------------------------------------------------------------------------
// bpt_update
// Next-state logic: EMA period correction, warm-up count, miss and restart.
// ----------------------------------------------------------------------------
module bpt_update (
  input  bpt_pkg::state_t                st,
  input  bpt_pkg::cfg_t                  cfg,
  input  logic [bpt_pkg::MODE_BITS-1:0]  mode,
  input  bpt_pkg::time_t                 event_time,
  output bpt_pkg::state_t                st_nxt
);
  import bpt_pkg::*;

  time_t gap;
  time_t err;
  logic  err_neg;
  time_t err_mag;
  time_t corr;
  time_t est_upd;
  logic [LIMIT_BITS-1:0] cnt_inc;

  // wrap-safe gap and signed error against the estimate
  assign gap     = event_time - st.last_beacon;
  assign err     = gap - st.period_cur;
  assign err_neg = err[TIME_BITS-1];
  assign err_mag = err_neg ? (~err + time_t'(1)) : err;

  always_comb begin
    corr = err_mag >> st.lat_shift;
    // a nonzero error always moves the estimate by at least one
    if ((corr == '0) && (err != '0)) begin
      corr = time_t'(1);
    end
  end

  assign est_upd = err_neg ? (st.period_cur - corr) : (st.period_cur + corr);
  assign cnt_inc = (st.warm_cnt < st.lat_limit) ? (st.warm_cnt + 1'b1) : st.warm_cnt;

  always_comb begin
    st_nxt = st;
    unique case (mode_t'(mode))
      MODE_BEACON: begin
        if (st.have_ref) begin
          st_nxt.period_cur = est_upd;
        end
        st_nxt.last_beacon = event_time;
        st_nxt.have_ref    = 1'b1;
        st_nxt.warm_cnt    = cnt_inc;
        if (cnt_inc >= st.lat_limit) begin
          st_nxt.tracking = 1'b1;
        end
      end
      MODE_MISS: begin
        st_nxt.tracking = 1'b0;
        st_nxt.warm_cnt = '0;
        st_nxt.have_ref = 1'b0;
      end
      MODE_RESTART: begin
        st_nxt.period_cur  = cfg.period_seed;
        st_nxt.last_beacon = '0;
        st_nxt.have_ref    = 1'b0;
        st_nxt.warm_cnt    = '0;
        st_nxt.tracking    = 1'b0;
        st_nxt.lat_guard   = cfg.guard_time;
        st_nxt.lat_limit   = cfg.warmup_limit;
        st_nxt.lat_shift   = cfg.smoothing_shift;
      end
      default: st_nxt = st;  // unused code: state kept
    endcase
  end

endmodule

// ----- src/beacon_period_tracker.sv -----
// ----------------------------------------------------------------------------
// beacon_period_tracker
// Tracks a periodic beacon with an EMA period estimate and plans the receive
// window after every event.
// ----------------------------------------------------------------------------
// Pipeline: an event passes the input register, then the state update and the
//   result register, which take it only when the result slot is free.
// Throughput: one event per cycle while the result stream is not stalled; the
//   state feedback loop (subtract, shift, add) closes through the state register
//   alone, so events can arrive back to back.
// Reset: synchronous active-low rst_n clears config, tracker state and both
//   valid flags; the period estimate starts at zero; a restart loads the seed.
// ----------------------------------------------------------------------------
module beacon_period_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bpt_pkg::TIME_BITS-1:0]  in_tdata,   // [31:0] event_time
  input  logic [bpt_pkg::MODE_BITS-1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bpt_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] arm_time,
                                                      // [63:32] window_length,
                                                      // [95:64] period_estimate
  output logic                           out_tuser,  // [0] narrow_window
  // configuration write port
  input  logic                           cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpt_pkg::*;

  cfg_t   cfg;
  state_t st_r;
  state_t st_nxt;

  // input register
  logic                 in_v_r;
  logic [MODE_BITS-1:0] in_mode_r;
  time_t                in_time_r;

  // result register
  logic                  out_v_r;
  logic                  out_narrow_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // result plan derived from the updated state
  logic  plan_narrow;
  time_t plan_arm;
  time_t plan_len;

  logic advance;  // result slot free this cycle
  logic proc;     // item in the input register moves to the result register

  assign advance   = !out_v_r || out_tready;
  assign proc      = in_v_r && advance;
  // input register can take a new item only when it is empty or the result slot is free
  assign in_tready = !in_v_r || advance;

  bpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpt_update u_update (
    .st         (st_r),
    .cfg        (cfg),
    .mode       (in_mode_r),
    .event_time (in_time_r),
    .st_nxt     (st_nxt)
  );

  // window plan: narrow only when tracking with a phase reference
  assign plan_narrow = st_nxt.tracking && st_nxt.have_ref;
  assign plan_arm    = plan_narrow ?
                       (st_nxt.last_beacon + st_nxt.period_cur -
                        time_t'(st_nxt.lat_guard)) : '0;
  assign plan_len    = plan_narrow ? {st_nxt.lat_guard, 1'b0} : '0;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r <= in_tuser;
      in_time_r <= in_tdata;
    end
  end

  // tracker state: one update per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_narrow_r <= plan_narrow;
      out_data_r   <= {st_nxt.period_cur, plan_len, plan_arm};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_narrow_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // state only moves when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(st_r))
    else $error("tracker state changed without a processed item");

  // a miss clears tracking, reference and warm-up count
  a_miss_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (in_mode_r == MODE_MISS)) |=>
      (!st_r.tracking && !st_r.have_ref && (st_r.warm_cnt == '0)))
    else $error("miss did not clear tracking state");

  // tracking is only reached once warm-up is complete
  a_track_warm: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tracking |-> (st_r.warm_cnt >= st_r.lat_limit))
    else $error("tracking without completed warm-up");

  // a wide-window result carries no arm time or window length
  a_wide_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[2*TIME_BITS-1:0] == '0))
    else $error("window plan nonzero outside narrow mode");

  // an item held in the input register stays until it can move on
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && $stable(in_mode_r) && $stable(in_time_r)))
    else $error("input register lost a pending item");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - beacon period tracker testbench
// Sends beacon, miss, restart and unused events through the input stream and
// checks every window plan on the result stream against an in-bench model of
// the period tracker. The sender runs in random bursts, the receiver stalls in
// changing patterns, and register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpt_pkg::*;

  // Unused event code: the tracker must hold its state and report the plan
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  // Cycles without any transaction before the run is declared hung
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned EVENTS_PER_PHASE = 155;

  // Expected result of one event
  typedef struct packed {
    logic  narrow;
    time_t arm;
    time_t win_len;
    time_t period;
  } window_plan_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TIME_BITS-1:0]  in_tdata = '0;   // [31:0] event_time
  logic [MODE_BITS-1:0]  in_tuser = '0;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [31:0] arm_time, [63:32] window_length,
                                          // [95:64] period_estimate
  logic                  out_tuser;       // [0] narrow_window
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  beacon_period_tracker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker model: programmed registers plus the state they latch on restart
  // --------------------------------------------------------------------------
  time_t                 reg_seed = '0;
  logic [GUARD_BITS-1:0] reg_guard = '0;
  logic [LIMIT_BITS-1:0] reg_limit = '0;
  logic [SHIFT_BITS-1:0] reg_shift = '0;

  time_t                 est_period = '0;
  time_t                 ref_time = '0;
  logic                  ref_valid = 1'b0;
  logic [LIMIT_BITS-1:0] warm_cnt = '0;
  logic                  in_track = 1'b0;
  logic [GUARD_BITS-1:0] hold_guard = '0;
  logic [LIMIT_BITS-1:0] hold_limit = '0;
  logic [SHIFT_BITS-1:0] hold_shift = '0;

  window_plan_t expected_plans[$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 0;

  // Advance the model by one event and return the plan the block must report
  function automatic window_plan_t plan_after_event(logic [MODE_BITS-1:0] kind,
                                                    time_t stamp);
    time_t        gap;
    time_t        err;
    time_t        mag;
    time_t        step;
    logic         neg;
    window_plan_t plan;
    case (kind)
      MODE_BEACON: begin
        if (ref_valid) begin
          // wrap-safe gap, signed error, truncating shift with a +/-1 floor
          gap = stamp - ref_time;
          err = gap - est_period;
          neg = err[TIME_BITS-1];
          mag = neg ? -err : err;   // most negative error stays unsigned
          step = mag >> hold_shift;
          if (step == '0 && err != '0) step = time_t'(1);
          est_period = neg ? est_period - step : est_period + step;
        end
        ref_time = stamp;
        ref_valid = 1'b1;
        if (warm_cnt < hold_limit) warm_cnt = warm_cnt + 1'b1;
        if (warm_cnt >= hold_limit) in_track = 1'b1;
      end
      MODE_MISS: begin
        // estimate survives a miss
        in_track = 1'b0;
        warm_cnt = '0;
        ref_valid = 1'b0;
      end
      MODE_RESTART: begin
        est_period = reg_seed;
        ref_time = '0;
        ref_valid = 1'b0;
        warm_cnt = '0;
        in_track = 1'b0;
        hold_guard = reg_guard;
        hold_limit = reg_limit;
        hold_shift = reg_shift;
      end
      default: begin
      end
    endcase
    plan.narrow = in_track && ref_valid;
    if (plan.narrow) begin
      plan.arm = ref_time + est_period - time_t'(hold_guard);
      plan.win_len = {hold_guard, 1'b0};
    end else begin
      plan.arm = '0;
      plan.win_len = '0;
    end
    plan.period = est_period;
    return plan;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------

  // One input transaction; idle gaps fall between random-length bursts.
  // valid is never lowered and raised in the same step.
  task automatic post_event(logic [MODE_BITS-1:0] kind, time_t stamp);
    int unsigned idle_gap;
    if (burst_left == 0) begin
      idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (idle_gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle_gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_plans.push_back(plan_after_event(kind, stamp));
    burst_left--;
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle_tracker();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_plans.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write; some callers set upper bits beyond the register width
  // so the block's truncation is exercised too
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PERIOD_SEED: reg_seed  = val;
      CFG_GUARD_TIME:  reg_guard = val[GUARD_BITS-1:0];
      CFG_WARMUP_LIM:  reg_limit = val[LIMIT_BITS-1:0];
      CFG_SMOOTH_SHFT: reg_shift = val[SHIFT_BITS-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before any restart: latched values are all zero, so zero warm-up limit
  // means tracking on the first beacon with a zero guard
  task automatic test_power_up();
    post_event(MODE_BEACON, 32'h0000_0010);
    post_event(MODE_BEACON, 32'hFFFF_FFFF);
    post_event(MODE_UNUSED, 32'h1234_5678);
    post_event(MODE_MISS, 32'hEDCB_A987);
  endtask

  // Largest seed and guard, zero limit and shift; timestamp wrap
  task automatic test_extremes();
    settle_tracker();
    write_reg(CFG_PERIOD_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_GUARD_TIME, 32'hFFFF_FFFF);
    write_reg(CFG_WARMUP_LIM, 32'hFFFF_0000);
    write_reg(CFG_SMOOTH_SHFT, 32'hFFFF_FFE0);
    post_event(MODE_RESTART, 32'hA5A5_5A5A);
    post_event(MODE_BEACON, 32'hFFFF_FFFF);
    post_event(MODE_BEACON, 32'h0000_0005);
    post_event(MODE_UNUSED, 32'h0000_0000);
    post_event(MODE_MISS, 32'hFFFF_FFFF);
    post_event(MODE_BEACON, 32'h0000_0000);   // first beacon, no reference
  endtask

  // Small errors under the widest shift nudge by one; zero error holds;
  // most negative error with shift 31 and with shift 0
  task automatic test_rounding();
    settle_tracker();
    write_reg(CFG_PERIOD_SEED, 32'd1000);
    write_reg(CFG_GUARD_TIME, 32'd10);
    write_reg(CFG_WARMUP_LIM, 32'd2);
    write_reg(CFG_SMOOTH_SHFT, 32'd31);
    post_event(MODE_RESTART, 32'h0);
    post_event(MODE_BEACON, 32'd0);
    post_event(MODE_BEACON, 32'd1000);         // exact period
    post_event(MODE_BEACON, 32'd2003);         // +3 rounds up to +1
    post_event(MODE_BEACON, 32'd2990);         // -14 rounds to -1
    post_event(MODE_BEACON, 32'd2990 + 32'h8000_03E8);
    settle_tracker();
    write_reg(CFG_SMOOTH_SHFT, 32'd0);
    post_event(MODE_RESTART, 32'hFFFF_0000);
    post_event(MODE_BEACON, 32'd0);
    post_event(MODE_BEACON, 32'h8000_03E8);   // full-size negative step
  endtask

  // Phases of jittered periodic beacons with misses, restarts and noise
  task automatic test_random_tracking();
    time_t                 stamp;
    time_t                 beacon_at;
    logic [CFG_DATA_W-1:0] wd;
    int                    jit_span;
    int                    jit;
    int unsigned           pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_tracker();
      case ($urandom_range(0, 5))
        0:       wd = '0;
        1:       wd = 32'hFFFF_FFFF;
        2:       wd = $urandom;
        default: wd = $urandom_range(50, 200000);
      endcase
      write_reg(CFG_PERIOD_SEED, wd);
      wd = $urandom;
      case ($urandom_range(0, 4))
        0:       wd[GUARD_BITS-1:0] = '0;
        1:       wd[GUARD_BITS-1:0] = '1;
        2:       ;
        default: wd[GUARD_BITS-1:0] = $urandom_range(0, 5000);
      endcase
      write_reg(CFG_GUARD_TIME, wd);
      wd = $urandom;
      case ($urandom_range(0, 7))
        0:       wd[LIMIT_BITS-1:0] = '0;
        1:       wd[LIMIT_BITS-1:0] = '1;   // never warms up in a phase
        default: wd[LIMIT_BITS-1:0] = $urandom_range(1, 8);
      endcase
      write_reg(CFG_WARMUP_LIM, wd);
      wd = $urandom;
      case ($urandom_range(0, 4))
        0:       wd[SHIFT_BITS-1:0] = '0;
        1:       wd[SHIFT_BITS-1:0] = '1;
        default: wd[SHIFT_BITS-1:0] = $urandom_range(1, 12);
      endcase
      write_reg(CFG_SMOOTH_SHFT, wd);

      case ($urandom_range(0, 4))
        0:       jit_span = 0;
        1:       jit_span = 2;
        2:       jit_span = 40;
        3:       jit_span = 3000;
        default: jit_span = 1 << 20;
      endcase
      beacon_at = $urandom;
      // Mostly start from a restart; otherwise the new registers stay pending
      if ($urandom_range(0, 3) != 0) post_event(MODE_RESTART, $urandom);

      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        stamp = $urandom;
        if (pick < 78) begin
          jit = int'($urandom_range(0, 2 * jit_span)) - jit_span;
          beacon_at = beacon_at + reg_seed + time_t'(jit);
          post_event(MODE_BEACON, beacon_at);
        end else if (pick < 84) begin
          beacon_at = stamp;
          post_event(MODE_BEACON, beacon_at);
        end else if (pick < 90) begin
          post_event(MODE_MISS, stamp);
        end else if (pick < 95) begin
          post_event(MODE_RESTART, stamp);
        end else begin
          post_event(MODE_UNUSED, stamp);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking: each result against the oldest expected plan
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    window_plan_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_plans.size() == 0) begin
        $error("result transaction with no event outstanding");
        mismatch_count++;
      end else begin
        want = expected_plans.pop_front();
        if (out_tuser !== want.narrow) begin
          $error("narrow_window: expected %0d actual %0d", want.narrow, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[31:0] !== want.arm) begin
          $error("arm_time: expected %0h actual %0h", want.arm, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[63:32] !== want.win_len) begin
          $error("window_length: expected %0h actual %0h", want.win_len,
                 out_tdata[63:32]);
          mismatch_count++;
        end
        if (out_tdata[95:64] !== want.period) begin
          $error("period_estimate: expected %0h actual %0h", want.period,
                 out_tdata[95:64]);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: the style is drawn anew for each random-length run
  // (always ready, coin flip, periodic drop, heavy stall)
  // --------------------------------------------------------------------------
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (stall_left % 4 != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Hang detection: too long with no transaction on either stream
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_power_up();
    test_extremes();
    test_rounding();
    test_random_tracking();
    settle_tracker();
    // wait on after settling so a stray result would still be caught
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bpt_pkg.sv
src/bpt_cfg.sv
src/bpt_update.sv
src/beacon_period_tracker.sv
sim/tb.sv
